// File: rtl/core/integer_to_radix_digits_macros.svh
// Assertion macros shared by the checker of the digit converter.
`ifndef INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_MACROS_SVH

// Checked on every clock edge once reset is released.
`define ITRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ITRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/itrd_pkg.sv
`timescale 1ns / 1ps

package itrd_pkg;

  // Port widths of the item and result fields.
  localparam int VALUE_IN_W = 64;
  localparam int RADIX_W    = 4;
  localparam int CHAR_W     = 6;
  localparam int DIGIT_W    = 4;

  // Number of low value bits used and depth of the digit store.
  localparam int VALUE_WIDTH = 64;
  localparam int MAX_DIGITS  = 64;

  // The divider retires this many quotient bits per clock cycle.
  localparam int BITS_PER_STEP = 4;
  localparam int DIV_W         = ((VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP)
                                 * BITS_PER_STEP;
  localparam int DIV_STEPS     = DIV_W / BITS_PER_STEP;
  localparam int STEP_W        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam int ADDR_W = $clog2(MAX_DIGITS);
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN  = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX  = RADIX_W'(10);
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  ASCII_NINE = CHAR_W'(57);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_EMIT
  } state_e;

endpackage

// File: rtl/core/itrd_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module itrd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/integer_to_radix_digits.sv
`timescale 1ns / 1ps

// Converts an unsigned integer into its ASCII digit string in a radix from 2
// to 10, most significant digit first. An item is taken when start is high
// and busy is low. Each digit then appears for exactly one cycle with
// digit_valid_o high, and last_o marks the final, least significant digit;
// the receiver cannot stall the block, so it must take every digit in the
// cycle it is shown. A value of zero gives the single character '0'. An item
// with a radix of 0, 1 or 11 to 15 is taken but gives no digits, and busy
// never rises for it. Numbers that need more digits than the store holds
// lose their most significant digits. One bit-serial restoring divider that
// retires four quotient bits a cycle is shared by all digits, so the digits
// are divided out one after another, least significant first. busy stays
// high through the division of every digit, the read state that starts the
// read of the digit store, and the output of the digits. The block takes its
// next item in the cycle after the last digit.
module integer_to_radix_digits (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [itrd_pkg::VALUE_IN_W-1:0] value_i,
  input  logic [itrd_pkg::RADIX_W-1:0]    radix_i,
  output logic                           digit_valid_o,
  output logic [itrd_pkg::CHAR_W-1:0]     digit_char_o,
  output logic                           last_o
);

  import itrd_pkg::*;

  // Sequencer state and control counters.
  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q;
  logic [CNT_W-1:0]    count_q;
  logic [ADDR_W-1:0]   idx_q;

  // Divider working registers. The work register starts as the dividend and
  // fills with quotient bits from the bottom as the dividend shifts out.
  logic [DIV_W-1:0]    work_q, work_d;
  logic [DIGIT_W-1:0]  rem_q, rem_d;
  logic [RADIX_W-1:0]  radix_q;

  logic                accept;
  logic                radix_ok;
  logic                div_last;
  logic                quot_zero;
  logic                store_room;
  logic [CNT_W-1:0]    count_inc;
  logic [CNT_W-1:0]    count_top;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [DIGIT_W-1:0]  ram_rdata;

  assign accept     = start && !busy;
  assign radix_ok   = (radix_i >= RADIX_MIN) && (radix_i <= RADIX_MAX);
  assign div_last   = (step_q == STEP_W'(DIV_STEPS - 1));
  assign quot_zero  = (work_d == '0);
  assign store_room = (count_q < CNT_W'(MAX_DIGITS));
  assign count_inc  = store_room ? count_q + CNT_W'(1) : count_q;
  assign count_top  = count_inc - CNT_W'(1);

  // Four steps of restoring division by the radix. The partial remainder
  // stays below the radix, so it never needs more than four bits.
  always_comb begin
    logic [DIGIT_W:0]         trial;
    logic [DIGIT_W-1:0]       rem;
    logic [BITS_PER_STEP-1:0] qbits;
    rem   = rem_q;
    qbits = '0;
    trial = '0;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      trial = {rem, work_q[DIV_W-1-i]};
      if (trial >= {1'b0, radix_q}) begin
        trial                    = trial - {1'b0, radix_q};
        qbits[BITS_PER_STEP-1-i] = 1'b1;
      end
      rem = trial[DIGIT_W-1:0];
    end
    rem_d  = rem;
    work_d = {work_q[DIV_W-BITS_PER_STEP-1:0], qbits};
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && radix_ok) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_last && quot_zero) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (idx_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs and store control. While digits stream out, the read address
  // runs one entry ahead of the digit on the result ports.
  always_comb begin
    busy          = 1'b1;
    digit_valid_o = 1'b0;
    last_o        = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = idx_q;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_DIV: begin
        ram_we = div_last && store_room;
      end
      ST_READ: begin
        ram_raddr = idx_q;
      end
      ST_EMIT: begin
        digit_valid_o = 1'b1;
        last_o        = (idx_q == '0);
        ram_raddr     = idx_q - ADDR_W'(1);
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  assign digit_char_o = ASCII_ZERO + CHAR_W'(ram_rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          step_q  <= '0;
          count_q <= '0;
        end
        ST_DIV: begin
          if (div_last) begin
            step_q  <= '0;
            count_q <= count_inc;
            if (quot_zero) begin
              idx_q <= count_top[ADDR_W-1:0];
            end
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        ST_READ: begin
          idx_q <= idx_q;
        end
        ST_EMIT: begin
          idx_q <= idx_q - ADDR_W'(1);
        end
        default: begin
          step_q <= '0;
        end
      endcase
    end
  end

  // Divider data path; it needs no reset since it is loaded on acceptance.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      work_q  <= DIV_W'(value_i[VALUE_WIDTH-1:0]);
      rem_q   <= '0;
      radix_q <= radix_i;
    end else if (state_q == ST_DIV) begin
      work_q <= work_d;
      rem_q  <= div_last ? '0 : rem_d;
    end
  end

  // Digit store, written least significant digit first.
  itrd_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(MAX_DIGITS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[ADDR_W-1:0]),
    .wdata_i(rem_d),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule

// File: rtl/core/itrd_checker.sv
`timescale 1ns / 1ps

`include "integer_to_radix_digits_macros.svh"

module itrd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic [itrd_pkg::VALUE_IN_W-1:0] value_i,
  input logic [itrd_pkg::RADIX_W-1:0]    radix_i,
  input logic                           digit_valid_o,
  input logic [itrd_pkg::CHAR_W-1:0]     digit_char_o,
  input logic                           last_o
);

  import itrd_pkg::*;

  logic good_item;
  logic char_ok;

  assign good_item = start && !busy && (radix_i >= RADIX_MIN) && (radix_i <= RADIX_MAX)
                     && (value_i == value_i);
  assign char_ok   = (digit_char_o >= ASCII_ZERO) && (digit_char_o <= ASCII_NINE);

  // Digits only come out while an item is in work.
  `ITRD_ASSERT_ALWAYS(a_digit_while_busy, digit_valid_o |-> busy, "digit shown while idle")

  // A well-formed item keeps the block busy, and no digit follows at once.
  `ITRD_ASSERT(a_item_starts_work, good_item |=> (busy && !digit_valid_o), "item not taken")

  // The final digit ends the item.
  `ITRD_ASSERT(a_last_ends_item, (digit_valid_o && last_o) |=> !busy, "busy after last digit")

  // The block only goes idle right after showing the final digit.
  `ITRD_ASSERT(a_idle_after_last, $fell(busy) |-> $past(digit_valid_o && last_o), "early idle")

  // Every character is a decimal digit.
  `ITRD_ASSERT(a_char_range, digit_valid_o |-> char_ok, "bad character")

endmodule

bind integer_to_radix_digits itrd_checker u_itrd_checker (.*);
